@@ rtl/core/ttct_pkg.sv @@
`timescale 1ns / 1ps
// types and codes shared by the time-tagged command table
// no dependencies

package ttct_pkg;

   localparam int SLOT_IDX_W   = 4;
   localparam int COUNT_W      = 5;
   localparam int HANDLE_W     = 16;
   localparam int ID_W         = 16;
   localparam int PORT_TIME_W  = 32;
   localparam int CSR_W        = 5;
   localparam int RESULT_LIMIT = 16;

   typedef enum logic [2:0] {
      REQ_LOAD         = 3'd0,
      REQ_ABORT_HANDLE = 3'd1,
      REQ_ABORT_ID     = 3'd2,
      REQ_TICK         = 3'd3,
      REQ_FLUSH        = 3'd4
   } req_code_type;

   typedef enum logic [2:0] {
      EVT_LOADED       = 3'd0,
      EVT_REJ_INVALID  = 3'd1,
      EVT_REJ_FULL     = 3'd2,
      EVT_ABORTED      = 3'd3,
      EVT_RELEASED     = 3'd4
   } event_code_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic free;
   } slot_cmd_type;

endpackage

@@ rtl/core/time_tagged_command_table.sv @@
`timescale 1ns / 1ps
// time-tagged command table top level: request sequencer, result staging
// depends on ttct_pkg, ttct_slot_store, ttct_match_unit
//
// usage
// - req channel: one beat per request (load, abort by handle, abort by id,
//   tick, flush). req_ready is high only while the sequencer is idle.
// - rsp channel: one beat per loaded, rejected, aborted or released command;
//   the final beat of a request carries rsp_last_of_run. a request that
//   touches nothing (or an unknown req_type) gives no beat at all.
// - csr channel: writes the active table size and empties the table; taken
//   only while idle and no request is offered. no beat results.
// - timing: the request is taken, then the scan visits one active slot per
//   cycle while it is not stalled, then the final beat is handed over. the
//   scan goes through the single shared comparator. rejections made when
//   the request is taken and unknown requests skip the scan. loads and aborts
//   by handle stop at the first hit.
// - stalls: results pass through a holding register and an output register,
//   so the scan keeps running while one beat waits; it pauses only when both
//   are full. the output register holds its beat until rsp_ready.
// - reset: synchronous, clears all busy flags, the pending count and the
//   output; the size returns to the full table.

module time_tagged_command_table import ttct_pkg::*; #(
   parameter int MAX_SLOTS = 16,
   parameter int TIME_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [2:0]             req_type,
   input  logic [HANDLE_W-1:0]    req_cmd_handle,
   input  logic [ID_W-1:0]        req_cmd_id,
   input  logic                   req_cmd_valid,
   input  logic [PORT_TIME_W-1:0] req_release_time,
   input  logic [PORT_TIME_W-1:0] req_now_time,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [2:0]             rsp_event_code,
   output logic [SLOT_IDX_W-1:0]  rsp_slot_index,
   output logic [HANDLE_W-1:0]    rsp_out_handle,
   output logic [ID_W-1:0]        rsp_out_id,
   output logic [COUNT_W-1:0]     rsp_pending_after,
   output logic                   rsp_last_of_run,
   // configuration write
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_W-1:0]       csr_slots_in_use
);

   // table depth is capped by the result limit; times beyond the port width carry nothing
   localparam int SLOT_CNT = (MAX_SLOTS < RESULT_LIMIT) ? MAX_SLOTS : RESULT_LIMIT;
   localparam int IDXW     = (SLOT_CNT > 1) ? $clog2(SLOT_CNT) : 1;
   localparam int CNTW     = $clog2(SLOT_CNT + 1);
   localparam int TW       = (TIME_BITS < PORT_TIME_W) ? TIME_BITS : PORT_TIME_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DONE
   } state_type;

   // sequencer state
   state_type           state_ff,   state_in;
   logic [IDXW-1:0]     idx_ff,     idx_in;
   logic [CNTW-1:0]     size_ff,    size_in;
   logic [CNTW-1:0]     pending_ff, pending_in;

   // latched request
   req_code_type        kind_ff,    kind_in;
   logic [HANDLE_W-1:0] key_handle_ff, key_handle_in;
   logic [ID_W-1:0]     key_id_ff,  key_id_in;
   logic [TW-1:0]       key_time_ff, key_time_in;

   // holding register: the newest result, kept until we know if it is last
   logic                hold_valid_ff, hold_valid_in;
   event_code_type      hold_code_ff,  hold_code_in;
   logic [IDXW-1:0]     hold_slot_ff,  hold_slot_in;
   logic [HANDLE_W-1:0] hold_handle_ff, hold_handle_in;
   logic [ID_W-1:0]     hold_id_ff,    hold_id_in;
   logic [CNTW-1:0]     hold_count_ff, hold_count_in;

   // output register
   logic                rsp_valid_ff,  rsp_valid_in;
   event_code_type      rsp_code_ff,   rsp_code_in;
   logic [IDXW-1:0]     rsp_slot_ff,   rsp_slot_in;
   logic [HANDLE_W-1:0] rsp_handle_ff, rsp_handle_in;
   logic [ID_W-1:0]     rsp_id_ff,     rsp_id_in;
   logic [CNTW-1:0]     rsp_count_ff,  rsp_count_in;
   logic                rsp_last_ff,   rsp_last_in;

   // slot store and compare unit
   slot_cmd_type        store_cmd;
   logic                rd_busy;
   logic [HANDLE_W-1:0] rd_handle;
   logic [ID_W-1:0]     rd_id;
   logic [TW-1:0]       rd_time;
   logic                hit;

   logic                req_fire;
   logic                csr_fire;
   logic                out_free;
   logic                scan_last;
   logic                stop_on_hit;

   ttct_slot_store #(
      .SLOT_CNT (SLOT_CNT),
      .IDXW     (IDXW),
      .TW       (TW)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .cmd       (store_cmd),
      .idx       (idx_ff),
      .wr_handle (key_handle_ff),
      .wr_id     (key_id_ff),
      .wr_time   (key_time_ff),
      .rd_busy   (rd_busy),
      .rd_handle (rd_handle),
      .rd_id     (rd_id),
      .rd_time   (rd_time)
   );

   ttct_match_unit #(
      .TW (TW)
   ) u_match (
      .mode         (kind_ff),
      .busy         (rd_busy),
      .entry_handle (rd_handle),
      .entry_id     (rd_id),
      .entry_time   (rd_time),
      .key_handle   (key_handle_ff),
      .key_id       (key_id_ff),
      .key_time     (key_time_ff),
      .hit          (hit)
   );

   assign req_ready   = (state_ff == S_IDLE);
   assign csr_ready   = (state_ff == S_IDLE) && !req_valid;
   assign req_fire    = req_valid && req_ready;
   assign csr_fire    = csr_valid && csr_ready;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign scan_last   = ((CNTW'(idx_ff) + 1'b1) == size_ff);
   // single-result requests end the scan at the first hit
   assign stop_on_hit = (kind_ff == REQ_LOAD) || (kind_ff == REQ_ABORT_HANDLE);

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      size_in        = size_ff;
      pending_in     = pending_ff;
      kind_in        = kind_ff;
      key_handle_in  = key_handle_ff;
      key_id_in      = key_id_ff;
      key_time_in    = key_time_ff;
      hold_valid_in  = hold_valid_ff;
      hold_code_in   = hold_code_ff;
      hold_slot_in   = hold_slot_ff;
      hold_handle_in = hold_handle_ff;
      hold_id_in     = hold_id_ff;
      hold_count_in  = hold_count_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_code_in    = rsp_code_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_handle_in  = rsp_handle_ff;
      rsp_id_in      = rsp_id_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_last_in    = rsp_last_ff;
      store_cmd      = '0;

      // output beat taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (csr_fire) begin
               // size saturates into 1..table depth, table empties
               if (csr_slots_in_use == '0) begin
                  size_in = CNTW'(1);
               end else if (csr_slots_in_use > CSR_W'(SLOT_CNT)) begin
                  size_in = CNTW'(SLOT_CNT);
               end else begin
                  size_in = csr_slots_in_use[CNTW-1:0];
               end
               pending_in      = '0;
               store_cmd.clear = 1'b1;
            end
            if (req_fire) begin
               kind_in       = req_code_type'(req_type);
               key_handle_in = req_cmd_handle;
               key_id_in     = req_cmd_id;
               key_time_in   = (req_type == REQ_LOAD) ? req_release_time[TW-1:0]
                                                      : req_now_time[TW-1:0];
               idx_in         = '0;
               hold_slot_in   = '0;
               hold_handle_in = req_cmd_handle;
               hold_id_in     = req_cmd_id;
               hold_count_in  = pending_ff;
               if (req_type == REQ_LOAD && !req_cmd_valid) begin
                  // invalid wins over full
                  hold_valid_in = 1'b1;
                  hold_code_in  = EVT_REJ_INVALID;
                  state_in      = S_DONE;
               end else if (req_type == REQ_LOAD && pending_ff >= size_ff) begin
                  hold_valid_in = 1'b1;
                  hold_code_in  = EVT_REJ_FULL;
                  state_in      = S_DONE;
               end else if (req_type inside {[REQ_LOAD:REQ_FLUSH]}) begin
                  state_in = S_SCAN;
               end else begin
                  // unknown request, nothing to report
                  state_in = S_DONE;
               end
            end
         end

         S_SCAN: begin
            if (hit) begin
               if (!hold_valid_ff || out_free) begin
                  // older result goes out, not last
                  if (hold_valid_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_code_in   = hold_code_ff;
                     rsp_slot_in   = hold_slot_ff;
                     rsp_handle_in = hold_handle_ff;
                     rsp_id_in     = hold_id_ff;
                     rsp_count_in  = hold_count_ff;
                     rsp_last_in   = 1'b0;
                  end
                  hold_valid_in = 1'b1;
                  hold_slot_in  = idx_ff;
                  if (kind_ff == REQ_LOAD) begin
                     store_cmd.load = 1'b1;
                     pending_in     = pending_ff + 1'b1;
                     hold_code_in   = EVT_LOADED;
                     hold_handle_in = key_handle_ff;
                     hold_id_in     = key_id_ff;
                     hold_count_in  = pending_ff + 1'b1;
                  end else begin
                     store_cmd.free = 1'b1;
                     pending_in     = (pending_ff != '0) ? pending_ff - 1'b1 : pending_ff;
                     hold_code_in   = (kind_ff == REQ_TICK) ? EVT_RELEASED : EVT_ABORTED;
                     hold_handle_in = rd_handle;
                     hold_id_in     = rd_id;
                     hold_count_in  = (pending_ff != '0) ? pending_ff - 1'b1 : pending_ff;
                  end
                  if (stop_on_hit || scan_last) begin
                     state_in = S_DONE;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                  end
               end
            end else if (scan_last) begin
               // no free slot found for a load: report full
               if (kind_ff == REQ_LOAD) begin
                  hold_valid_in  = 1'b1;
                  hold_code_in   = EVT_REJ_FULL;
                  hold_slot_in   = '0;
                  hold_handle_in = key_handle_ff;
                  hold_id_in     = key_id_ff;
                  hold_count_in  = pending_ff;
               end
               state_in = S_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         S_DONE: begin
            if (!hold_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               // final beat of this request
               rsp_valid_in  = 1'b1;
               rsp_code_in   = hold_code_ff;
               rsp_slot_in   = hold_slot_ff;
               rsp_handle_in = hold_handle_ff;
               rsp_id_in     = hold_id_ff;
               rsp_count_in  = hold_count_ff;
               rsp_last_in   = 1'b1;
               hold_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      key_handle_ff  <= key_handle_in;
      key_id_ff      <= key_id_in;
      key_time_ff    <= key_time_in;
      idx_ff         <= idx_in;
      hold_code_ff   <= hold_code_in;
      hold_slot_ff   <= hold_slot_in;
      hold_handle_ff <= hold_handle_in;
      hold_id_ff     <= hold_id_in;
      hold_count_ff  <= hold_count_in;
      rsp_code_ff    <= rsp_code_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_handle_ff  <= rsp_handle_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_last_ff    <= rsp_last_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         size_ff       <= CNTW'(SLOT_CNT);
         pending_ff    <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         size_ff       <= size_in;
         pending_ff    <= pending_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_event_code    = rsp_code_ff;
   assign rsp_slot_index    = SLOT_IDX_W'(rsp_slot_ff);
   assign rsp_out_handle    = rsp_handle_ff;
   assign rsp_out_id        = rsp_id_ff;
   assign rsp_pending_after = COUNT_W'(rsp_count_ff);
   assign rsp_last_of_run   = rsp_last_ff;

   // occupancy never exceeds the active size
   a_pending_le_size: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= size_ff)
      else $error("pending count above active table size");

   // a finished request leaves nothing in the holding register
   a_idle_hold_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !hold_valid_ff)
      else $error("held result left behind at idle");

   // a size write empties the table
   a_csr_clears: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> pending_ff == '0)
      else $error("size write did not empty the table");

   // a scan only runs in range of the active size
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> CNTW'(idx_ff) < size_ff)
      else $error("scan index beyond active size");

endmodule

@@ rtl/core/ttct_slot_store.sv @@
`timescale 1ns / 1ps
// slot storage: busy flags plus handle, id and time tag per slot
// depends on ttct_pkg

module ttct_slot_store import ttct_pkg::*; #(
   parameter int SLOT_CNT = 16,
   parameter int IDXW     = 4,
   parameter int TW       = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  slot_cmd_type        cmd,
   input  logic [IDXW-1:0]     idx,
   input  logic [HANDLE_W-1:0] wr_handle,
   input  logic [ID_W-1:0]     wr_id,
   input  logic [TW-1:0]       wr_time,
   output logic                rd_busy,
   output logic [HANDLE_W-1:0] rd_handle,
   output logic [ID_W-1:0]     rd_id,
   output logic [TW-1:0]       rd_time
);

   logic [SLOT_CNT-1:0] busy_ff;
   logic [SLOT_CNT-1:0] busy_in;
   logic [HANDLE_W-1:0] slot_handle_ff [SLOT_CNT];
   logic [ID_W-1:0]     slot_id_ff     [SLOT_CNT];
   logic [TW-1:0]       slot_time_ff   [SLOT_CNT];

   always_comb begin
      busy_in = busy_ff;
      if (cmd.clear) begin
         busy_in = '0;
      end else if (cmd.load) begin
         busy_in[idx] = 1'b1;
      end else if (cmd.free) begin
         busy_in[idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && !cmd.clear) begin
         slot_handle_ff[idx] <= wr_handle;
         slot_id_ff[idx]     <= wr_id;
         slot_time_ff[idx]   <= wr_time;
      end
   end

   assign rd_busy   = busy_ff[idx];
   assign rd_handle = slot_handle_ff[idx];
   assign rd_id     = slot_id_ff[idx];
   assign rd_time   = slot_time_ff[idx];

endmodule

@@ rtl/core/ttct_match_unit.sv @@
`timescale 1ns / 1ps
// shared compare unit: one equality / less-or-equal comparator per scan step
// depends on ttct_pkg

module ttct_match_unit import ttct_pkg::*; #(
   parameter int TW = 32
) (
   input  req_code_type        mode,
   input  logic                busy,
   input  logic [HANDLE_W-1:0] entry_handle,
   input  logic [ID_W-1:0]     entry_id,
   input  logic [TW-1:0]       entry_time,
   input  logic [HANDLE_W-1:0] key_handle,
   input  logic [ID_W-1:0]     key_id,
   input  logic [TW-1:0]       key_time,
   output logic                hit
);

   localparam int CW = (TW > HANDLE_W) ? TW : HANDLE_W;

   logic [CW-1:0] opa;
   logic [CW-1:0] opb;
   logic          eq;
   logic          le;

   // operand select feeding the single comparator
   always_comb begin
      case (mode)
         REQ_ABORT_HANDLE: begin
            opa = CW'(entry_handle);
            opb = CW'(key_handle);
         end
         REQ_ABORT_ID: begin
            opa = CW'(entry_id);
            opb = CW'(key_id);
         end
         REQ_TICK: begin
            opa = CW'(entry_time);
            opb = CW'(key_time);
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
   end

   assign eq = (opa == opb);
   assign le = (opa <= opb);

   always_comb begin
      case (mode)
         REQ_LOAD:         hit = !busy;
         REQ_ABORT_HANDLE: hit = busy && eq;
         REQ_ABORT_ID:     hit = busy && eq;
         REQ_TICK:         hit = busy && le;
         REQ_FLUSH:        hit = busy;
         default:          hit = 1'b0;
      endcase
   end

endmodule
